>>> hdl/srd_pkg.sv
// ---------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the segment reassembler with duplicate
// filtering.
// ---------------------------------------------------------------------------
package srd_pkg;

  localparam int SEG_BYTES = 9;
  localparam logic [2:0] FILLER_INDEX = 3'd7;

  localparam int IDX_W    = 3;
  localparam int HDR_W    = 5;
  localparam int START_W  = 48;
  localparam int WIN_W    = 32;
  localparam int SIZE_W   = 6;
  localparam int POS_W    = 6;
  localparam int ADDR_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_WIN   = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd9;

  typedef struct packed {
    logic               is_text;
    logic [IDX_W-1:0]   index;
    logic               last;
    logic [63:0]        head;
    logic [7:0]         tail;
    logic [START_W-1:0] start;
  } seg_t;

  typedef struct packed {
    logic cmp;  // compare the held segment against the reference
    logic upd;  // take the held segment as the new reference
  } dedup_ctl_t;

endpackage

>>> hdl/srd_dedup.sv
// ---------------------------------------------------------------------------
// srd_dedup
// Reference segment store and registered duplicate comparison.
// ---------------------------------------------------------------------------
module srd_dedup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srd_pkg::dedup_ctl_t            ctl,
  input  srd_pkg::seg_t                  seg,
  input  logic [srd_pkg::WIN_W-1:0]      dup_window,
  output logic                           is_dup
);

  logic                              have_prev_r;
  logic [srd_pkg::HDR_W-1:0]         prev_hdr_r;
  logic [63:0]                       prev_head_r;
  logic [7:0]                        prev_tail_r;
  logic [srd_pkg::START_W-1:0]       prev_start_r;
  logic                              eq_r;
  logic [srd_pkg::START_W-1:0]       dist_r;
  logic [srd_pkg::HDR_W-1:0]         hdr;
  logic [srd_pkg::START_W-1:0]       dist_nxt;

  assign hdr = {seg.is_text, seg.index, seg.last};

  always_comb begin
    if (seg.start >= prev_start_r) begin
      dist_nxt = seg.start - prev_start_r;
    end else begin
      dist_nxt = prev_start_r - seg.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (ctl.upd) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      prev_hdr_r   <= hdr;
      prev_head_r  <= seg.head;
      prev_tail_r  <= seg.tail;
      prev_start_r <= seg.start;
    end
    if (ctl.cmp) begin
      eq_r   <= have_prev_r && (hdr == prev_hdr_r) && (seg.head == prev_head_r)
                && (seg.tail == prev_tail_r);
      dist_r <= dist_nxt;
    end
  end

  assign is_dup = eq_r && (dist_r <= {{(srd_pkg::START_W - srd_pkg::WIN_W){1'b0}}, dup_window});

endmodule

>>> hdl/srd_buf.sv
// ---------------------------------------------------------------------------
// srd_buf
// Burst byte store: 64 bytes per channel, one write and one registered read
// per cycle.
// ---------------------------------------------------------------------------
module srd_buf (
  input  logic                        clk,
  input  logic                        we,
  input  logic [srd_pkg::ADDR_W-1:0]  waddr,
  input  logic [7:0]                  wdata,
  input  logic                        re,
  input  logic [srd_pkg::ADDR_W-1:0]  raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [2**srd_pkg::ADDR_W];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read while no new read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/segment_reassembler_dedup_top.sv
// Sequence: an accepted beat is compared (S_CMP) and decided (S_DEC); a stored
//   segment is then written to the buffer one byte at a time (S_WR), and a last
//   segment of nonzero size has each burst byte read (S_RD) and loaded (S_LOAD).
// Flow: a beat is taken only in S_IDLE, after the previous one and any burst it
//   releases are done; output stalls hold S_LOAD; the byte store read is registered.
// Reset: synchronous, active low; clears control, channel state and the
//   reference flag, sizes return to 9 and the window to 0. No clearing pass.
// ---------------------------------------------------------------------------
// segment_reassembler_dedup_top
// Drops repeated segments, reassembles text and signalling bursts in a
// byte store and emits each completed burst at its configured length.
// ---------------------------------------------------------------------------
module segment_reassembler_dedup_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // segment input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_seg_is_text,
  input  logic [2:0]                       in_seg_index,
  input  logic                             in_seg_last,
  input  logic [63:0]                      in_seg_bytes_head,
  input  logic [7:0]                       in_seg_byte_tail,
  input  logic [47:0]                      in_start_sample,
  // burst byte output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_burst_byte,
  output logic                             out_burst_is_text,
  output logic                             out_burst_end,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a segment beat
  localparam logic [2:0] S_CMP  = 3'd1;  // register equality and distance
  localparam logic [2:0] S_DEC  = 3'd2;  // duplicate, filler and sequence decision
  localparam logic [2:0] S_WR   = 3'd3;  // write the nine bytes, one a cycle
  localparam logic [2:0] S_RD   = 3'd4;  // issue a buffer read for byte k
  localparam logic [2:0] S_LOAD = 3'd5;  // move byte k into the output register

  logic [2:0]                   state_r, state_nxt;
  srd_pkg::seg_t                seg_r;
  logic [srd_pkg::SIZE_W-1:0]   sig_size_r, text_size_r;
  logic [srd_pkg::WIN_W-1:0]    dup_win_r;
  logic [1:0]                   active_r;
  logic [srd_pkg::IDX_W-1:0]    next_idx_r [2];
  logic [3:0]                   j_r;          // byte within the segment being written
  logic [srd_pkg::POS_W-1:0]    k_r;          // burst byte being emitted
  logic [srd_pkg::POS_W-1:0]    cnt_r;        // stored bytes of the burst
  logic [srd_pkg::SIZE_W-1:0]   size_r;       // bytes to emit
  logic                         out_valid_r;
  logic [7:0]                   out_byte_r;
  logic                         out_text_r;
  logic                         out_end_r;

  srd_pkg::dedup_ctl_t          dd_ctl;
  logic                         is_dup;
  logic                         in_fire;
  logic                         ch;
  logic                         in_seq;
  logic                         wr_done;
  logic                         out_free;
  logic                         emit_end;
  logic [7:0]                   head_bytes [8];
  logic [7:0]                   wbyte;
  logic [srd_pkg::POS_W-1:0]    wpos;
  logic [srd_pkg::IDX_W:0]      idx_inc;
  logic [srd_pkg::POS_W-1:0]    cnt_nxt;
  logic [srd_pkg::SIZE_W-1:0]   chan_size;
  logic                         mem_re;
  logic [7:0]                   mem_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign ch        = seg_r.is_text;

  // hold the beat for the whole of its processing
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seg_r <= '{is_text: in_seg_is_text, index: in_seg_index, last: in_seg_last,
                 head: in_seg_bytes_head, tail: in_seg_byte_tail,
                 start: in_start_sample};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_size_r  <= srd_pkg::SIZE_RESET;
      text_size_r <= srd_pkg::SIZE_RESET;
      dup_win_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srd_pkg::CFG_SIG_SIZE:  sig_size_r  <= cfg_data[srd_pkg::SIZE_W-1:0];
        srd_pkg::CFG_TEXT_SIZE: text_size_r <= cfg_data[srd_pkg::SIZE_W-1:0];
        srd_pkg::CFG_DUP_WIN:   dup_win_r   <= cfg_data[srd_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // duplicate filter: compare in S_CMP, take the new reference in S_DEC
  assign dd_ctl.cmp = (state_r == S_CMP);
  assign dd_ctl.upd = (state_r == S_DEC) && !is_dup;

  srd_dedup u_dedup (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (dd_ctl),
    .seg        (seg_r),
    .dup_window (dup_win_r),
    .is_dup     (is_dup)
  );

  // a continuing segment must match the channel's expected index
  assign in_seq = active_r[ch] && (seg_r.index == next_idx_r[ch]);

  // byte 0 sits in the top bits of the head
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      head_bytes[b] = seg_r.head[8*(7-b) +: 8];
    end
  end
  assign wbyte = (j_r == 4'(srd_pkg::SEG_BYTES - 1)) ? seg_r.tail : head_bytes[j_r[2:0]];

  // write position index*9 + j, never beyond 62
  assign wpos    = {seg_r.index, 3'b000} + {3'b000, seg_r.index} + {2'b00, j_r};
  assign wr_done = (j_r == 4'(srd_pkg::SEG_BYTES - 1));
  assign idx_inc = {1'b0, seg_r.index} + 4'd1;
  assign cnt_nxt = {idx_inc[2:0], 3'b000} + {3'b000, idx_inc[2:0]};
  assign chan_size = ch ? text_size_r : sig_size_r;

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;
  assign emit_end = ({1'b0, k_r} + 7'd1) == {1'b0, size_r};
  assign mem_re   = (state_r == S_RD);

  srd_buf u_buf (
    .clk   (clk),
    .we    (state_r == S_WR),
    .waddr ({ch, wpos}),
    .wdata (wbyte),
    .re    (mem_re),
    .raddr ({ch, k_r}),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CMP;
      end
      S_CMP: state_nxt = S_DEC;
      S_DEC: begin
        if (is_dup || seg_r.index == srd_pkg::FILLER_INDEX) begin
          state_nxt = S_IDLE;
        end else if (seg_r.index == '0 || in_seq) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WR: begin
        if (wr_done) begin
          state_nxt = (seg_r.last && chan_size != '0) ? S_RD : S_IDLE;
        end
      end
      S_RD: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) state_nxt = emit_end ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_r      <= '0;
      next_idx_r[0] <= '0;
      next_idx_r[1] <= '0;
      out_valid_r   <= 1'b0;
      j_r           <= '0;
      k_r           <= '0;
    end else begin
      state_r <= state_nxt;

      // channel bookkeeping: restart, advance or drop the partial burst
      if (state_r == S_DEC && !is_dup && seg_r.index != srd_pkg::FILLER_INDEX) begin
        if (seg_r.index == '0 || in_seq) begin
          active_r[ch]   <= 1'b1;
          next_idx_r[ch] <= idx_inc[srd_pkg::IDX_W-1:0];
        end else begin
          active_r[ch]   <= 1'b0;
          next_idx_r[ch] <= '0;
        end
      end
      // a last segment closes the channel once its bytes are stored
      if (state_r == S_WR && wr_done && seg_r.last) begin
        active_r[ch]   <= 1'b0;
        next_idx_r[ch] <= '0;
      end

      if (state_r == S_DEC) begin
        j_r <= '0;
      end else if (state_r == S_WR) begin
        j_r <= j_r + 4'd1;
      end

      if (state_r == S_WR) begin
        k_r <= '0;
      end else if (state_r == S_LOAD && out_free) begin
        k_r <= k_r + 6'd1;
      end

      // output beat valid: set on load, drop once taken
      if (state_r == S_LOAD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR && wr_done) begin
      cnt_r  <= cnt_nxt;
      size_r <= chan_size;
    end
    // positions past the stored bytes pad with zero
    if (state_r == S_LOAD && out_free) begin
      out_byte_r <= (k_r < cnt_r) ? mem_rdata : 8'd0;
      out_text_r <= ch;
      out_end_r  <= emit_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_burst_byte    = out_byte_r;
  assign out_burst_is_text = out_text_r;
  assign out_burst_end     = out_end_r;

endmodule

>>> hdl/srd_checker.sv
// ---------------------------------------------------------------------------
// srd_checker
// Port-level checks on the segment reassembler, bound to its top level.
// ---------------------------------------------------------------------------
module srd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_burst_byte,
  input logic        out_burst_is_text,
  input logic        out_burst_end
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_burst_byte) && $stable(out_burst_is_text)
                                && $stable(out_burst_end))
    else $error("stalled output beat changed");

  // after a segment is taken, input ready drops and output valid does not rise while it is compared and decided
  a_in_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("output appeared too soon after a segment beat");

  // no segment is taken while a burst is still being emitted
  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_burst_end |-> !in_ready)
    else $error("input ready in the middle of a burst");

endmodule

bind segment_reassembler_dedup_top srd_checker u_srd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_burst_byte    (out_burst_byte),
  .out_burst_is_text (out_burst_is_text),
  .out_burst_end     (out_burst_end)
);

>>> bench/srd_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srd_bench_checker
// Watches the segment, burst byte and register channels of the reassembler,
// keeps its own copy of the dedup, channel and register state, predicts the
// burst bytes of every accepted segment and compares them in order.
// ---------------------------------------------------------------------------
module srd_bench_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_seg_is_text,
  input  logic [srd_pkg::IDX_W-1:0]      in_seg_index,
  input  logic                           in_seg_last,
  input  logic [63:0]                    in_seg_bytes_head,
  input  logic [7:0]                     in_seg_byte_tail,
  input  logic [srd_pkg::START_W-1:0]    in_start_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_burst_byte,
  input  logic                           out_burst_is_text,
  input  logic                           out_burst_end,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             segments_seen,
  output int                             dups_dropped,
  output int                             bursts_checked,
  output int                             bytes_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_text;
    logic       burst_end;
  } burst_beat_t;

  burst_beat_t       expected_bytes[$];

  logic [srd_pkg::SIZE_W-1:0] sig_size;
  logic [srd_pkg::SIZE_W-1:0] text_size;
  logic [srd_pkg::WIN_W-1:0]  dup_window;

  logic                       ref_valid;
  srd_pkg::seg_t              ref_seg;
  logic                       chan_open [2];
  logic [srd_pkg::IDX_W-1:0]  chan_next [2];
  logic [7:0]                 byte_store [2][64];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  // Work out the burst bytes that one accepted segment releases.
  task automatic predict_segment(input srd_pkg::seg_t s);
    logic [srd_pkg::START_W-1:0] gap_smp;
    logic [7:0]                  b;
    burst_beat_t                 nb;
    int                          ch;
    int                          fill;
    int                          emit;
    int                          i;
    int                          k;
    gap_smp = (s.start >= ref_seg.start) ? s.start - ref_seg.start
                                         : ref_seg.start - s.start;
    if (ref_valid &&
        s[$bits(srd_pkg::seg_t)-1:srd_pkg::START_W] ==
        ref_seg[$bits(srd_pkg::seg_t)-1:srd_pkg::START_W] &&
        gap_smp <= dup_window) begin
      dups_dropped++;
      return;
    end
    ref_valid = 1'b1;
    ref_seg   = s;
    if (s.index == srd_pkg::FILLER_INDEX) return;
    ch = s.is_text;
    if (s.index == 0) begin
      chan_open[ch] = 1'b1;
      chan_next[ch] = '0;
    end else if (!chan_open[ch] || s.index != chan_next[ch]) begin
      chan_open[ch] = 1'b0;
      chan_next[ch] = '0;
      return;
    end
    fill = s.index * srd_pkg::SEG_BYTES;
    for (i = 0; i < 8; i++) begin
      byte_store[ch][fill + i] = s.head[63 - 8*i -: 8];
    end
    byte_store[ch][fill + 8] = s.tail;
    chan_next[ch] = s.index + 3'd1;
    fill = fill + srd_pkg::SEG_BYTES;
    if (!s.last) return;
    emit = s.is_text ? int'(text_size) : int'(sig_size);
    for (k = 0; k < emit; k++) begin
      b  = (k < fill) ? byte_store[ch][k] : 8'h00;
      nb = '{data: b, is_text: s.is_text, burst_end: (k == emit - 1)};
      expected_bytes.insert(expected_bytes.size(), nb);
    end
    chan_open[ch] = 1'b0;
    chan_next[ch] = '0;
  endtask

  always @(posedge clk) begin
    srd_pkg::seg_t s;
    burst_beat_t   want;
    if (!rst_n) begin
      sig_size       = srd_pkg::SIZE_RESET;
      text_size      = srd_pkg::SIZE_RESET;
      dup_window     = '0;
      ref_valid      = 1'b0;
      ref_seg        = '0;
      chan_open[0]   = 1'b0;
      chan_open[1]   = 1'b0;
      chan_next[0]   = '0;
      chan_next[1]   = '0;
      mismatches     = 0;
      segments_seen  = 0;
      dups_dropped   = 0;
      bursts_checked = 0;
      bytes_checked  = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srd_pkg::CFG_SIG_SIZE:  sig_size   = cfg_data[srd_pkg::SIZE_W-1:0];
          srd_pkg::CFG_TEXT_SIZE: text_size  = cfg_data[srd_pkg::SIZE_W-1:0];
          srd_pkg::CFG_DUP_WIN:   dup_window = cfg_data[srd_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("burst byte %02h with nothing expected", out_burst_byte));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.burst_end) bursts_checked++;
          if (out_burst_byte !== want.data)
            report_mismatch($sformatf("burst_byte got %02h want %02h",
                                      out_burst_byte, want.data));
          if (out_burst_is_text !== want.is_text)
            report_mismatch($sformatf("burst_is_text got %b want %b",
                                      out_burst_is_text, want.is_text));
          if (out_burst_end !== want.burst_end)
            report_mismatch($sformatf("burst_end got %b want %b",
                                      out_burst_end, want.burst_end));
        end
      end
      if (in_valid && in_ready) begin
        s.is_text = in_seg_is_text;
        s.index   = in_seg_index;
        s.last    = in_seg_last;
        s.head    = in_seg_bytes_head;
        s.tail    = in_seg_byte_tail;
        s.start   = in_start_sample;
        segments_seen++;
        predict_segment(s);
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives segments and register writes into the reassembler, pulls burst
// bytes with random back-pressure and gives the verdict from the checker.
// ---------------------------------------------------------------------------
module testbench;

  localparam int EXT_W = srd_pkg::START_W - srd_pkg::WIN_W;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_seg_is_text = 1'b0;
  logic [srd_pkg::IDX_W-1:0]      in_seg_index = '0;
  logic                           in_seg_last = 1'b0;
  logic [63:0]                    in_seg_bytes_head = '0;
  logic [7:0]                     in_seg_byte_tail = '0;
  logic [srd_pkg::START_W-1:0]    in_start_sample = '0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_burst_byte;
  logic                           out_burst_is_text;
  logic                           out_burst_end;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int segments_seen;
  int dups_dropped;
  int bursts_checked;
  int bytes_checked;

  // stimulus bookkeeping
  srd_pkg::seg_t               last_sent = '0;
  logic [srd_pkg::START_W-1:0] sample_clock = '0;
  logic [srd_pkg::WIN_W-1:0]   cur_window = '0;
  int                          useful_sent = 0;
  int                          src_calm = 0;
  int                          settings_used = 1;
  logic                        sink_long_hold = 1'b0;

  segment_reassembler_dedup_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_seg_is_text    (in_seg_is_text),
    .in_seg_index      (in_seg_index),
    .in_seg_last       (in_seg_last),
    .in_seg_bytes_head (in_seg_bytes_head),
    .in_seg_byte_tail  (in_seg_byte_tail),
    .in_start_sample   (in_start_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_burst_byte    (out_burst_byte),
    .out_burst_is_text (out_burst_is_text),
    .out_burst_end     (out_burst_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // The checker sits beside the block and sees every channel; it owns
  // prediction and comparison, the top only drives and judges.
  srd_bench_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, even with every segment
  // closing a 63-byte burst against the longest receiver stalls.
  initial begin
    #25000000;
    $display("segment_reassembler_dedup_top test failed");
    $finish;
  end

  function automatic srd_pkg::seg_t make_segment(input logic t, input logic [2:0] idx,
                                                 input logic l, input logic [63:0] h,
                                                 input logic [7:0] b,
                                                 input logic [srd_pkg::START_W-1:0] st);
    srd_pkg::seg_t s;
    s.is_text = t;
    s.index   = idx;
    s.last    = l;
    s.head    = h;
    s.tail    = b;
    s.start   = st;
    return s;
  endfunction

  // Random content; the sample count mostly creeps forward but now and
  // then jumps anywhere in the 48-bit range.
  function automatic srd_pkg::seg_t random_segment(input logic t, input logic [2:0] idx,
                                                   input logic l);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) sample_clock = wide[srd_pkg::START_W-1:0];
    else sample_clock = sample_clock + $urandom_range(0, 3000);
    return make_segment(t, idx, l, {$urandom, $urandom}, 8'($urandom), sample_clock);
  endfunction

  // Offer one segment beat after a random gap and hold it until taken.
  // Valid is only lowered when a gap follows, never dropped and re-raised
  // on the same edge.
  task automatic send_seg(input srd_pkg::seg_t s);
    int gap;
    if (src_calm > 0) begin
      gap = 0;
      src_calm--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) src_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_seg_is_text    <= s.is_text;
    in_seg_index      <= s.index;
    in_seg_last       <= s.last;
    in_seg_bytes_head <= s.head;
    in_seg_byte_tail  <= s.tail;
    in_start_sample   <= s.start;
    @(posedge clk iff in_ready);
    // fillers and repeats do not count as real traffic
    if (s.index != srd_pkg::FILLER_INDEX &&
        s[$bits(srd_pkg::seg_t)-1:srd_pkg::START_W] !=
        last_sent[$bits(srd_pkg::seg_t)-1:srd_pkg::START_W]) begin
      useful_sent++;
    end
    last_sent = s;
  endtask

  // Resend the previous beat at a distance on either side of the window
  // edge, so that some are dropped and some slip through.
  task automatic repeat_last_segment();
    srd_pkg::seg_t               s;
    logic [srd_pkg::START_W-1:0] d;
    logic [srd_pkg::START_W-1:0] win;
    s   = last_sent;
    win = {{EXT_W{1'b0}}, cur_window};
    case ($urandom_range(0, 3))
      0:       d = '0;
      1:       d = win;
      2:       d = win + 48'd1;
      default: d = (cur_window == '1) ? {{EXT_W{1'b0}}, $urandom}
                                      : {{EXT_W{1'b0}}, $urandom_range(0, cur_window)};
    endcase
    if ($urandom_range(0, 1) == 1 && s.start >= d) s.start = s.start - d;
    else s.start = s.start + d;
    send_seg(s);
  endtask

  // Mostly whole bursts with random content, sprinkled with fillers,
  // repeats and stray segments on the other channel; the rest broken
  // bursts and pure noise.
  task automatic send_random_traffic();
    int            kind;
    int            n;
    int            i;
    int            j;
    int            fault;
    logic          ch;
    logic          broken;
    srd_pkg::seg_t s;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      s = random_segment(1'($urandom), 3'($urandom), 1'($urandom));
      send_seg(s);
      return;
    end
    broken = (kind >= 70);
    ch     = 1'($urandom);
    n      = broken ? $urandom_range(2, 7) : $urandom_range(1, 7);
    j      = $urandom_range(0, n - 1);
    fault  = $urandom_range(0, 2);
    for (i = 0; i < n; i++) begin
      s = random_segment(ch, 3'(i), i == n - 1);
      if (broken && i == j) begin
        if (fault == 0) s.index = 3'($urandom_range(1, 6));
        else if (fault == 1 && i > 0) continue;
        else s.last = 1'b0;
      end
      send_seg(s);
      case ($urandom_range(0, 19))
        0:       send_seg(random_segment(1'($urandom), srd_pkg::FILLER_INDEX, 1'($urandom)));
        1, 2:    repeat_last_segment();
        3:       send_seg(random_segment(~ch, 3'd0, 1'($urandom)));
        default: ;
      endcase
    end
  endtask

  // Pause the sender until every predicted byte has left, then give the
  // block time to finish any segment that releases nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == srd_pkg::CFG_DUP_WIN) cur_window = val;
  endtask

  // Receiver: random stall before each beat, calm stretches with no stall,
  // and one long hold-off so the block backs up into its input.
  initial begin : sink_side
    int   gap;
    int   calm;
    logic hold_done;
    calm      = 0;
    hold_done = 1'b0;
    forever begin
      if (sink_long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 60);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff (out_valid && out_ready));
    end
  end

  initial begin : stimulus
    srd_pkg::seg_t s;
    int            ph;
    int            target;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes (9 bytes each) and a zero window.
    // An all-zero beat first: it must not match the cleared reference.
    s = make_segment(1'b0, 3'd0, 1'b0, 64'h0, 8'h00, 48'h0);
    send_seg(s);
    send_seg(s);                                     // exact repeat: drop
    send_seg(make_segment(1'b0, 3'd1, 1'b1, '1, 8'hFF, 48'h1));      // truncate to first 9
    s = make_segment(1'b1, 3'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 8'h5A, '1);
    send_seg(s);
    s.start = '0;                                    // full-range distance, no wrap
    send_seg(s);
    send_seg(make_segment(1'b1, srd_pkg::FILLER_INDEX, 1'b1, {$urandom, $urandom}, 8'hC3,
                          48'h5));
    send_seg(make_segment(1'b0, 3'd3, 1'b0, 64'hA5A5, 8'h11, 48'h6)); // not open: clear
    send_seg(make_segment(1'b0, 3'd0, 1'b0, 64'h1111, 8'h22, 48'h7));
    send_seg(make_segment(1'b0, 3'd2, 1'b0, 64'h3333, 8'h44, 48'h8)); // skipped index
    send_seg(make_segment(1'b0, 3'd1, 1'b1, 64'h5555, 8'h66, 48'h9)); // channel now closed
    // longest burst: seven segments, 63 stored bytes
    for (int i = 0; i < 7; i++) begin
      send_seg(random_segment(1'b1, 3'(i), i == 6));
    end
    // interleave the two channels
    send_seg(random_segment(1'b0, 3'd0, 1'b0));
    send_seg(random_segment(1'b1, 3'd0, 1'b0));
    send_seg(random_segment(1'b0, 3'd1, 1'b1));
    settle();

    // Extremes: one signalling byte, 63 text bytes, widest window.
    write_reg(srd_pkg::CFG_SIG_SIZE, 32'd1);
    write_reg(srd_pkg::CFG_TEXT_SIZE, 32'd63);
    write_reg(srd_pkg::CFG_DUP_WIN, 32'hFFFF_FFFF);
    settings_used++;
    send_seg(random_segment(1'b1, 3'd1, 1'b1));     // text still open: pad with zeros
    s = make_segment(1'b0, 3'd0, 1'b1, {$urandom, $urandom}, 8'h80, 48'h1000_0000_0000);
    send_seg(s);
    s.start = 48'h1000_FFFF_FFFF;                    // at the window edge: drop
    send_seg(s);
    s.start = 48'h1001_0000_0000;                    // one past: release again
    send_seg(s);
    settle();

    // Zero signalling size (upper data bits are ignored), five text bytes.
    write_reg(srd_pkg::CFG_SIG_SIZE, 32'h40);
    write_reg(srd_pkg::CFG_TEXT_SIZE, 32'h45);
    write_reg(srd_pkg::CFG_DUP_WIN, 32'd5);
    settings_used++;
    send_seg(random_segment(1'b0, 3'd0, 1'b1));     // consumed, nothing emitted
    s = make_segment(1'b1, 3'd0, 1'b1, {$urandom, $urandom}, 8'h01, 48'h20);
    send_seg(s);
    s.start = 48'h1B;                                // five samples earlier: drop
    send_seg(s);
    s.start = 48'h1A;                                // six earlier: release
    send_seg(s);
    settle();

    // Random phases, each under its own register setting.
    sample_clock = 48'h100;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(srd_pkg::CFG_SIG_SIZE, 32'($urandom_range(1, 63)));
          write_reg(srd_pkg::CFG_TEXT_SIZE, 32'($urandom_range(1, 63)));
          write_reg(srd_pkg::CFG_DUP_WIN, 32'($urandom_range(0, 2000)));
        end
        1: begin
          write_reg(srd_pkg::CFG_SIG_SIZE, 32'd63);
          write_reg(srd_pkg::CFG_TEXT_SIZE, 32'd1);
          write_reg(srd_pkg::CFG_DUP_WIN, 32'd0);
          sink_long_hold = 1'b1;   // receiver backs off while we keep sending
        end
        2: begin
          write_reg(srd_pkg::CFG_SIG_SIZE, 32'($urandom_range(0, 12)));
          write_reg(srd_pkg::CFG_TEXT_SIZE, 32'($urandom_range(40, 63)));
          write_reg(srd_pkg::CFG_DUP_WIN, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(srd_pkg::CFG_SIG_SIZE, 32'd9);
          write_reg(srd_pkg::CFG_TEXT_SIZE, 32'd9);
          write_reg(srd_pkg::CFG_DUP_WIN, $urandom);
        end
      endcase
      settings_used++;
      target = useful_sent + 96;
      while (useful_sent < target) send_random_traffic();
      settle();
    end

    $display("Covered %0d segments (%0d dropped as repeats) under %0d register settings;",
             segments_seen, dups_dropped, settings_used);
    $display("checked %0d bursts carrying %0d bytes, %0d mismatches.",
             bursts_checked, bytes_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("segment_reassembler_dedup_top test passed");
    end else begin
      $display("segment_reassembler_dedup_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/srd_pkg.sv
hdl/srd_dedup.sv
hdl/srd_buf.sv
hdl/segment_reassembler_dedup_top.sv
hdl/srd_checker.sv
bench/srd_checker.sv
bench/testbench.sv
